// ----- src/tlb_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB package
// Shared widths, opcodes, the tag record and the recency update codes.
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int OPC_W       = 2;
    localparam int DATA_W      = 16;
    localparam int CFG_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(16);

    localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPC_W-1:0] OP_FILL   = 2'd1;
    localparam logic [OPC_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OPC_W-1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] process;
        logic [DATA_W-1:0] page;
        logic [DATA_W-1:0] frame;
    } t_tag;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_TOUCH,
        RK_ENTER,
        RK_REMOVE
    } t_rank_op;

endpackage

// ----- src/tlb_tag_mem.sv -----
// ----------------------------------------------------------------------------
// TLB tag memory
// One write port and one registered read port for the process, page and
// frame of every entry.
// ----------------------------------------------------------------------------
module tlb_tag_mem #(
    parameter int ENTRIES = tlb_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  tlb_pkg::t_tag              i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output tlb_pkg::t_tag              o_rdata
);

    tlb_pkg::t_tag r_mem [ENTRIES];
    tlb_pkg::t_tag r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tlb_rank.sv -----
// ----------------------------------------------------------------------------
// TLB recency ranks
// Valid bits and age ranks of all entries, updated in parallel when an
// entry is touched, entered or removed.
// ----------------------------------------------------------------------------
module tlb_rank #(
    parameter int ENTRIES = tlb_pkg::ENTRIES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  tlb_pkg::t_rank_op                           i_op,
    input  logic [$clog2(ENTRIES)-1:0]                  i_idx,
    output logic [ENTRIES-1:0]                          o_valid,
    output logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0]     o_age
);

    localparam int AGE_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0]             r_valid;
    logic [ENTRIES-1:0]             n_valid;
    logic [ENTRIES-1:0][AGE_W-1:0]  r_age;
    logic [ENTRIES-1:0][AGE_W-1:0]  n_age;
    logic [AGE_W-1:0]               age_k;

    assign age_k = r_age[i_idx];

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        for (int j = 0; j < ENTRIES; j++) begin
            if ((AGE_W'(j) != i_idx) && r_valid[j]) begin
                unique case (i_op)
                    tlb_pkg::RK_TOUCH: begin
                        if (r_age[j] < age_k) n_age[j] = r_age[j] + AGE_W'(1);
                    end
                    tlb_pkg::RK_ENTER: begin
                        n_age[j] = r_age[j] + AGE_W'(1);
                    end
                    tlb_pkg::RK_REMOVE: begin
                        if (r_age[j] > age_k) n_age[j] = r_age[j] - AGE_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
        unique case (i_op)
            tlb_pkg::RK_TOUCH: begin
                n_age[i_idx] = '0;
            end
            tlb_pkg::RK_ENTER: begin
                n_age[i_idx]   = '0;
                n_valid[i_idx] = 1'b1;
            end
            tlb_pkg::RK_REMOVE: begin
                n_age[i_idx]   = '0;
                n_valid[i_idx] = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    assign o_valid = r_valid;
    assign o_age   = r_age;

endmodule

// ----- src/tlb_ctrl.sv -----
// ----------------------------------------------------------------------------
// TLB sequencer
// Scans the entries one at a time through a single tag and age comparator,
// then commits the fill or recency update and registers the result.
// ----------------------------------------------------------------------------
module tlb_ctrl #(
    parameter int ENTRIES = tlb_pkg::ENTRIES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [tlb_pkg::OPC_W-1:0]               i_opcode,
    input  logic [tlb_pkg::DATA_W-1:0]              i_process_id,
    input  logic [tlb_pkg::DATA_W-1:0]              i_page_number,
    input  logic [tlb_pkg::DATA_W-1:0]              i_frame_number,
    input  logic [$clog2(ENTRIES+1)-1:0]            i_used,
    output logic                                    o_idle,
    output logic                                    o_mem_we,
    output logic [$clog2(ENTRIES)-1:0]              o_mem_waddr,
    output tlb_pkg::t_tag                           o_mem_wdata,
    output logic [$clog2(ENTRIES)-1:0]              o_mem_raddr,
    input  tlb_pkg::t_tag                           i_mem_rdata,
    output tlb_pkg::t_rank_op                       o_rank_op,
    output logic [$clog2(ENTRIES)-1:0]              o_rank_idx,
    input  logic [ENTRIES-1:0]                      i_entry_valid,
    input  logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0] i_entry_age,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_hit,
    output logic [tlb_pkg::DATA_W-1:0]              o_found_frame
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int AGE_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic [tlb_pkg::OPC_W-1:0]   r_op;
    logic [tlb_pkg::DATA_W-1:0]  r_pid;
    logic [tlb_pkg::DATA_W-1:0]  r_page;
    logic [tlb_pkg::DATA_W-1:0]  r_frame;
    logic [IDX_W-1:0]            r_idx;
    logic [CNT_W-1:0]            r_lim;
    logic                        r_found;
    logic [IDX_W-1:0]            r_tgt;
    logic [tlb_pkg::DATA_W-1:0]  r_hit_frame;
    logic [IDX_W-1:0]            r_vict_idx;
    logic [AGE_W-1:0]            r_vict_age;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [tlb_pkg::DATA_W-1:0]  r_out_frame;

    logic                        accept;
    logic                        out_free;
    logic                        entry_v;
    logic [AGE_W-1:0]            entry_age;
    logic                        pid_eq;
    logic                        page_eq;
    logic                        last;
    logic [CNT_W-1:0]            lim_in;

    assign accept    = (r_state == S_IDLE) && i_valid;
    assign out_free  = !r_out_valid || !i_stall;
    assign entry_v   = i_entry_valid[r_idx];
    assign entry_age = i_entry_age[r_idx];
    assign pid_eq    = (i_mem_rdata.process == r_pid);
    assign page_eq   = (i_mem_rdata.page == r_page);
    assign last      = (CNT_W'(r_idx) == (r_lim - CNT_W'(1)));
    assign lim_in    = (i_opcode == tlb_pkg::OP_FLUSH) ? CNT_W'(ENTRIES) : i_used;

    always_comb begin
        o_rank_op   = tlb_pkg::RK_NONE;
        o_rank_idx  = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tgt;
        if (r_state == S_CMP && r_op == tlb_pkg::OP_FLUSH && entry_v && pid_eq) begin
            o_rank_op = tlb_pkg::RK_REMOVE;
        end else if (r_state == S_FIN && out_free) begin
            if (r_op == tlb_pkg::OP_LOOKUP && r_found) begin
                o_rank_op  = tlb_pkg::RK_TOUCH;
                o_rank_idx = r_tgt;
            end else if (r_op == tlb_pkg::OP_FILL && r_found) begin
                o_rank_op  = tlb_pkg::RK_ENTER;
                o_rank_idx = r_tgt;
                o_mem_we   = 1'b1;
            end else if (r_op == tlb_pkg::OP_FILL && r_lim != '0) begin
                o_rank_op   = tlb_pkg::RK_TOUCH;
                o_rank_idx  = r_vict_idx;
                o_mem_we    = 1'b1;
                o_mem_waddr = r_vict_idx;
            end
        end
    end

    assign o_mem_wdata = '{process: r_pid, page: r_page, frame: r_frame};
    assign o_mem_raddr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op        <= i_opcode;
                        r_pid       <= i_process_id;
                        r_page      <= i_page_number;
                        r_frame     <= i_frame_number;
                        r_idx       <= '0;
                        r_lim       <= lim_in;
                        r_found     <= 1'b0;
                        r_hit_frame <= '0;
                        if (i_opcode == tlb_pkg::OP_NOP || lim_in == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_op == tlb_pkg::OP_LOOKUP && entry_v && pid_eq && page_eq) begin
                        r_found     <= 1'b1;
                        r_tgt       <= r_idx;
                        r_hit_frame <= i_mem_rdata.frame;
                        r_state     <= S_FIN;
                    end else if (r_op == tlb_pkg::OP_FILL && !entry_v) begin
                        r_found <= 1'b1;
                        r_tgt   <= r_idx;
                        r_state <= S_FIN;
                    end else begin
                        if (r_idx == '0 || entry_age > r_vict_age) begin
                            r_vict_idx <= r_idx;
                            r_vict_age <= entry_age;
                        end
                        if (last) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= (r_op == tlb_pkg::OP_LOOKUP) && r_found;
                        r_out_frame <= r_hit_frame;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_idle        = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_found_frame = r_out_frame;

endmodule

// ----- src/tlb_lru_pid_tagged.sv -----
// ----------------------------------------------------------------------------
// Process-tagged translation buffer with LRU replacement
// Fully associative page translation buffer: lookup, fill and flush by
// process id, with exact recency ranks for victim choice.
// ----------------------------------------------------------------------------
// Usage: items enter on i_valid with o_stall low and carry an opcode
// (lookup, fill, flush), a process id, a page and a frame. Every item yields
// exactly one result item on o_valid, taken when i_stall is low: hit and the
// found frame for a lookup, zeros for anything else.
// The entries are scanned one at a time, each through a read state and a
// compare state, by a single comparator reading the tag memory. The scan
// covers up to the active count for lookup and fill (a lookup stops at
// its first match, a fill at its first free entry) and all ENTRIES for a
// flush. The block takes one item at a time and holds o_stall high until
// the item is finished.
// A finished result sits in an output register; the next item is accepted
// while it waits, and only its commit waits until the receiver takes it.
// The configuration channel writes active_entries, taken only while idle.
// After reset all entries are invalid, all ranks are zero and active_entries
// is 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_lru_pid_tagged #(
    parameter int ENTRIES = tlb_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tlb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tlb_pkg::OPC_W-1:0]    i_opcode,
    input  logic [tlb_pkg::DATA_W-1:0]   i_process_id,
    input  logic [tlb_pkg::DATA_W-1:0]   i_page_number,
    input  logic [tlb_pkg::DATA_W-1:0]   i_frame_number,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [tlb_pkg::DATA_W-1:0]   o_found_frame
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > tlb_pkg::CFG_W) ? CNT_W : tlb_pkg::CFG_W;

    logic [tlb_pkg::CFG_W-1:0]          r_active;
    logic [CMP_W-1:0]                   active_ext;
    logic [CNT_W-1:0]                   used;
    logic                               idle;

    logic                               mem_we;
    logic [IDX_W-1:0]                   mem_waddr;
    tlb_pkg::t_tag                      mem_wdata;
    logic [IDX_W-1:0]                   mem_raddr;
    tlb_pkg::t_tag                      mem_rdata;

    tlb_pkg::t_rank_op                  rank_op;
    logic [IDX_W-1:0]                   rank_idx;
    logic [ENTRIES-1:0]                 entry_valid;
    logic [ENTRIES-1:0][IDX_W-1:0]      entry_age;

    assign o_cfg_ready = idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= tlb_pkg::ACTIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    assign active_ext = CMP_W'(r_active);
    assign used = (active_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(active_ext);

    tlb_tag_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tlb_rank #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (rank_op),
        .i_idx   (rank_idx),
        .o_valid (entry_valid),
        .o_age   (entry_age)
    );

    tlb_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_process_id   (i_process_id),
        .i_page_number  (i_page_number),
        .i_frame_number (i_frame_number),
        .i_used         (used),
        .o_idle         (idle),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_rank_op      (rank_op),
        .o_rank_idx     (rank_idx),
        .i_entry_valid  (entry_valid),
        .i_entry_age    (entry_age),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_found_frame  (o_found_frame)
    );

endmodule
